### src/sm83alu_pkg.sv
package sm83alu_pkg;

    localparam int unsigned OpWidth   = 5;
    localparam int unsigned WordWidth = 16;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned BitIxWidth = 3;

    // tdata widths on the two stream sides, rounded up to whole bytes
    localparam int unsigned InDataWidth  = 48;
    localparam int unsigned OutDataWidth = 24;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD   = 5'd0,
        OP_SUB   = 5'd1,
        OP_AND   = 5'd2,
        OP_XOR   = 5'd3,
        OP_OR    = 5'd4,
        OP_CP    = 5'd5,
        OP_INC8  = 5'd6,
        OP_DEC8  = 5'd7,
        OP_INC16 = 5'd8,
        OP_DEC16 = 5'd9,
        OP_ADD16 = 5'd10,
        OP_ADDSB = 5'd11,
        OP_DAA   = 5'd12,
        OP_BIT   = 5'd13,
        OP_SET   = 5'd14,
        OP_RES   = 5'd15,
        OP_RL    = 5'd16,
        OP_RR    = 5'd17,
        OP_RLC   = 5'd18,
        OP_RRC   = 5'd19,
        OP_SLA   = 5'd20,
        OP_SRA   = 5'd21,
        OP_SRL   = 5'd22,
        OP_SWAP  = 5'd23
    } t_alu_op;

    typedef struct packed {
        logic                  flag_c_in;
        logic                  flag_h_in;
        logic                  flag_n_in;
        logic                  flag_z_in;
        logic [BitIxWidth-1:0] bit_index;
        logic                  carry_in;
        logic [WordWidth-1:0]  operand_b;
        logic [WordWidth-1:0]  operand_a;
        logic [OpWidth-1:0]    mode;
    } t_alu_req;

    typedef struct packed {
        logic                 flag_c;
        logic                 flag_h;
        logic                 flag_n;
        logic                 flag_z;
        logic [WordWidth-1:0] result;
    } t_alu_rsp;

endpackage

### src/sm83_alu_with_flags.sv
// sm83-style alu (8-bit operations plus 16-bit inc, dec and adds) with z/n/h/c flags.
// one operation per beat, a new beat accepted every cycle unless tready is low; each
// beat passes through the input register, where the alu logic works on it, and then
// the result register, which takes it once the result side can accept it. flags that an
// operation does not touch pass through as given on the input. tready drops only while
// both registers are full and the result side holds off tready.
module sm83_alu_with_flags (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // mode[4:0], operand_a[20:5], operand_b[36:21], carry_in[37], bit_index[40:38],
    // flag_z_in[41], flag_n_in[42], flag_h_in[43], flag_c_in[44], zero fill
    input  logic [sm83alu_pkg::InDataWidth-1:0]    i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // result[15:0], flag_z[16], flag_n[17], flag_h[18], flag_c[19], zero fill
    output logic [sm83alu_pkg::OutDataWidth-1:0]   o_m_axis_tdata
);
    import sm83alu_pkg::*;

    localparam int unsigned ReqBits = $bits(t_alu_req);
    localparam int unsigned RspBits = $bits(t_alu_rsp);

    logic     r_in_v;
    t_alu_req r_in;
    logic     r_out_v;
    t_alu_rsp r_out;
    t_alu_rsp w_rsp;
    logic     w_out_ready;
    logic     w_in_ready;

    assign w_out_ready = !r_out_v || i_m_axis_tready;
    assign w_in_ready  = !r_in_v || w_out_ready;

    sm83alu_core u_core (
        .i_req (r_in),
        .o_rsp (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_v <= i_s_axis_tvalid;
            end
            if (w_out_ready) begin
                r_out_v <= r_in_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_s_axis_tvalid) begin
            r_in <= t_alu_req'(i_s_axis_tdata[ReqBits-1:0]);
        end
        if (w_out_ready && r_in_v) begin
            r_out <= w_rsp;
        end
    end

    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {{(OutDataWidth-RspBits){1'b0}}, r_out};

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_v && !r_out_v))
        else $error("pipeline valid bits not cleared by reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_m_axis_tready) |=> r_out_v)
        else $error("stalled result dropped");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && w_out_ready) |=> r_out_v)
        else $error("beat in input register did not reach result register");

    a_add_clears_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && w_out_ready && (t_alu_op'(r_in.mode) == OP_ADD)) |=> !r_out.flag_n)
        else $error("add left n set");

    a_sub_sets_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && w_out_ready
         && ((t_alu_op'(r_in.mode) == OP_SUB) || (t_alu_op'(r_in.mode) == OP_CP)))
        |=> r_out.flag_n)
        else $error("subtract or compare left n clear");

endmodule

### src/sm83alu_core.sv
module sm83alu_core (
    input  sm83alu_pkg::t_alu_req i_req,
    output sm83alu_pkg::t_alu_rsp o_rsp
);
    import sm83alu_pkg::*;

    logic [ByteWidth-1:0] a;
    logic [ByteWidth-1:0] b;
    logic [WordWidth-1:0] a16;
    logic [WordWidth-1:0] b16;
    logic                 cin_sub;
    logic [ByteWidth:0]   sum9;
    logic [4:0]           sum_nib;
    logic [ByteWidth:0]   diff9;
    logic [4:0]           diff_nib;
    logic [ByteWidth:0]   plain9;
    logic [4:0]           plain_nib;
    logic [WordWidth:0]   sum17;
    logic [12:0]          sum13;
    logic [ByteWidth-1:0] bit_mask;
    logic                 daa_hi;
    logic [ByteWidth-1:0] daa_up;
    logic [ByteWidth-1:0] daa_dn;
    logic [ByteWidth-1:0] daa_res;
    logic [ByteWidth-1:0] byte_res;
    logic                 byte_zero;

    assign a16 = i_req.operand_a;
    assign b16 = i_req.operand_b;
    assign a   = a16[ByteWidth-1:0];
    assign b   = b16[ByteWidth-1:0];

    // cp never borrows in
    assign cin_sub = (t_alu_op'(i_req.mode) == OP_SUB) ? i_req.carry_in : 1'b0;

    assign sum9      = {1'b0, a} + {1'b0, b} + {8'd0, i_req.carry_in};
    assign sum_nib   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, i_req.carry_in};
    assign diff9     = {1'b0, a} - {1'b0, b} - {8'd0, cin_sub};
    assign diff_nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_sub};
    assign plain9    = {1'b0, a} + {1'b0, b};
    assign plain_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]};
    assign sum17     = {1'b0, a16} + {1'b0, b16};
    assign sum13     = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
    assign bit_mask  = 8'd1 << i_req.bit_index;

    // decimal adjust: the +0x60 leaves the low nibble alone, so test it on a
    assign daa_hi  = i_req.flag_c_in || (a > 8'h99);
    assign daa_up  = a + (daa_hi ? 8'h60 : 8'h00)
                       + ((i_req.flag_h_in || (a[3:0] > 4'h9)) ? 8'h06 : 8'h00);
    assign daa_dn  = a - (i_req.flag_c_in ? 8'h60 : 8'h00)
                       - (i_req.flag_h_in ? 8'h06 : 8'h00);
    assign daa_res = i_req.flag_n_in ? daa_dn : daa_up;

    always_comb begin
        unique case (t_alu_op'(i_req.mode))
            OP_ADD:  byte_res = sum9[ByteWidth-1:0];
            OP_SUB:  byte_res = diff9[ByteWidth-1:0];
            OP_CP:   byte_res = diff9[ByteWidth-1:0];
            OP_AND:  byte_res = a & b;
            OP_XOR:  byte_res = a ^ b;
            OP_OR:   byte_res = a | b;
            OP_INC8: byte_res = a + 8'd1;
            OP_DEC8: byte_res = a - 8'd1;
            OP_DAA:  byte_res = daa_res;
            OP_RL:   byte_res = {a[6:0], i_req.flag_c_in};
            OP_RR:   byte_res = {i_req.flag_c_in, a[7:1]};
            OP_RLC:  byte_res = {a[6:0], a[7]};
            OP_RRC:  byte_res = {a[0], a[7:1]};
            OP_SLA:  byte_res = {a[6:0], 1'b0};
            OP_SRA:  byte_res = {a[7], a[7:1]};
            OP_SRL:  byte_res = {1'b0, a[7:1]};
            OP_SWAP: byte_res = {a[3:0], a[7:4]};
            default: byte_res = a;
        endcase
    end

    assign byte_zero = (byte_res == '0);

    always_comb begin
        o_rsp.result = {8'd0, byte_res};
        o_rsp.flag_z = byte_zero;
        o_rsp.flag_n = 1'b0;
        o_rsp.flag_h = 1'b0;
        o_rsp.flag_c = 1'b0;
        unique case (t_alu_op'(i_req.mode))
            OP_ADD: begin
                o_rsp.flag_h = sum_nib[4];
                o_rsp.flag_c = sum9[ByteWidth];
            end
            OP_SUB: begin
                o_rsp.flag_n = 1'b1;
                o_rsp.flag_h = diff_nib[4];
                o_rsp.flag_c = diff9[ByteWidth];
            end
            OP_CP: begin
                o_rsp.result = {8'd0, a};
                o_rsp.flag_n = 1'b1;
                o_rsp.flag_h = diff_nib[4];
                o_rsp.flag_c = diff9[ByteWidth];
            end
            OP_AND: begin
                o_rsp.flag_h = 1'b1;
            end
            OP_XOR, OP_OR, OP_SWAP: begin
            end
            OP_INC8: begin
                o_rsp.flag_h = (a[3:0] == 4'hF);
                o_rsp.flag_c = i_req.flag_c_in;
            end
            OP_DEC8: begin
                o_rsp.flag_n = 1'b1;
                o_rsp.flag_h = (a[3:0] == 4'h0);
                o_rsp.flag_c = i_req.flag_c_in;
            end
            OP_INC16, OP_DEC16: begin
                o_rsp.result = (t_alu_op'(i_req.mode) == OP_INC16) ? a16 + 16'd1
                                                                    : a16 - 16'd1;
                o_rsp.flag_z = i_req.flag_z_in;
                o_rsp.flag_n = i_req.flag_n_in;
                o_rsp.flag_h = i_req.flag_h_in;
                o_rsp.flag_c = i_req.flag_c_in;
            end
            OP_ADD16: begin
                o_rsp.result = sum17[WordWidth-1:0];
                o_rsp.flag_z = i_req.flag_z_in;
                o_rsp.flag_h = sum13[12];
                o_rsp.flag_c = sum17[WordWidth];
            end
            OP_ADDSB: begin
                // h and c from the unsigned low-byte add
                o_rsp.result = a16 + {{8{b[7]}}, b};
                o_rsp.flag_z = 1'b0;
                o_rsp.flag_h = plain_nib[4];
                o_rsp.flag_c = plain9[ByteWidth];
            end
            OP_DAA: begin
                o_rsp.flag_n = i_req.flag_n_in;
                o_rsp.flag_c = i_req.flag_n_in ? i_req.flag_c_in : daa_hi;
            end
            OP_BIT: begin
                o_rsp.flag_z = ((a & bit_mask) == '0);
                o_rsp.flag_h = 1'b1;
                o_rsp.flag_c = i_req.flag_c_in;
            end
            OP_SET, OP_RES: begin
                o_rsp.result = {8'd0, (t_alu_op'(i_req.mode) == OP_SET) ? (a | bit_mask)
                                                                        : (a & ~bit_mask)};
                o_rsp.flag_z = i_req.flag_z_in;
                o_rsp.flag_n = i_req.flag_n_in;
                o_rsp.flag_h = i_req.flag_h_in;
                o_rsp.flag_c = i_req.flag_c_in;
            end
            OP_RL, OP_RLC, OP_SLA: begin
                o_rsp.flag_c = a[7];
            end
            OP_RR, OP_RRC, OP_SRA, OP_SRL: begin
                o_rsp.flag_c = a[0];
            end
            default: begin
                // codes past swap pass operand and flags through
                o_rsp.result = a16;
                o_rsp.flag_z = i_req.flag_z_in;
                o_rsp.flag_n = i_req.flag_n_in;
                o_rsp.flag_h = i_req.flag_h_in;
                o_rsp.flag_c = i_req.flag_c_in;
            end
        endcase
    end

endmodule

### verif/sm83_alu_with_flags_tb.sv
module sm83_alu_with_flags_tb;

    import sm83alu_pkg::*;

    // mode codes past the last operation pass operand_a and the flags through
    localparam logic [OpWidth-1:0] MODE_FIRST_UNUSED = 5'd24;
    localparam logic [OpWidth-1:0] MODE_LAST_UNUSED  = 5'd31;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    // mode, operand_a, operand_b, carry_in, bit_index, flag_z/n/h/c_in, zero fill
    logic [InDataWidth-1:0]  i_s_axis_tdata = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    // result, flag_z, flag_n, flag_h, flag_c, zero fill
    logic [OutDataWidth-1:0] o_m_axis_tdata;

    t_alu_rsp expected_rsp_q[$];
    int       mismatch_count = 0;
    int       send_idle_pct  = 0;
    int       recv_idle_pct  = 0;

    sm83_alu_with_flags dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_alu_rsp alu_predict(input t_alu_req req);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  r;
        logic [7:0]  bit_mask;
        logic [8:0]  wide9;
        logic [4:0]  nib5;
        logic [12:0] low13;
        logic [16:0] sum17;
        logic        cy;
        t_alu_rsp    rsp;
        a = req.operand_a[7:0];
        b = req.operand_b[7:0];
        bit_mask = 8'd1 << req.bit_index;
        rsp.result = req.operand_a;
        rsp.flag_z = req.flag_z_in;
        rsp.flag_n = req.flag_n_in;
        rsp.flag_h = req.flag_h_in;
        rsp.flag_c = req.flag_c_in;
        case (req.mode)
            OP_ADD: begin
                wide9 = {1'b0, a} + {1'b0, b} + {8'd0, req.carry_in};
                nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, req.carry_in};
                rsp = '{flag_c: wide9[8], flag_h: nib5[4], flag_n: 1'b0,
                        flag_z: (wide9[7:0] == 8'h00), result: {8'h00, wide9[7:0]}};
            end
            OP_SUB, OP_CP: begin
                cy = (req.mode == OP_CP) ? 1'b0 : req.carry_in;
                // borrow shows as bit 8 / bit 4 of the extended difference
                wide9 = {1'b0, a} - {1'b0, b} - {8'd0, cy};
                nib5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cy};
                rsp = '{flag_c: wide9[8], flag_h: nib5[4], flag_n: 1'b1,
                        flag_z: (wide9[7:0] == 8'h00),
                        result: {8'h00, (req.mode == OP_CP) ? a : wide9[7:0]}};
            end
            OP_AND, OP_XOR, OP_OR: begin
                r = (req.mode == OP_AND) ? (a & b) : (req.mode == OP_XOR) ? (a ^ b) : (a | b);
                rsp = '{flag_c: 1'b0, flag_h: (req.mode == OP_AND), flag_n: 1'b0,
                        flag_z: (r == 8'h00), result: {8'h00, r}};
            end
            OP_INC8: begin
                r = a + 8'd1;
                rsp.result = {8'h00, r};
                rsp.flag_z = (r == 8'h00);
                rsp.flag_n = 1'b0;
                rsp.flag_h = (a[3:0] == 4'hF);
            end
            OP_DEC8: begin
                r = a - 8'd1;
                rsp.result = {8'h00, r};
                rsp.flag_z = (r == 8'h00);
                rsp.flag_n = 1'b1;
                rsp.flag_h = (a[3:0] == 4'h0);
            end
            OP_INC16: rsp.result = req.operand_a + 16'd1;
            OP_DEC16: rsp.result = req.operand_a - 16'd1;
            OP_ADD16: begin
                sum17 = {1'b0, req.operand_a} + {1'b0, req.operand_b};
                low13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
                rsp.result = sum17[15:0];
                rsp.flag_n = 1'b0;
                rsp.flag_h = low13[12];
                rsp.flag_c = sum17[16];
            end
            OP_ADDSB: begin
                // h and c come from the unsigned low-byte add, not the signed one
                wide9 = {1'b0, a} + {1'b0, b};
                nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]};
                rsp = '{flag_c: wide9[8], flag_h: nib5[4], flag_n: 1'b0, flag_z: 1'b0,
                        result: req.operand_a + {{8{b[7]}}, b}};
            end
            OP_DAA: begin
                r = a;
                if (!req.flag_n_in) begin
                    if (req.flag_c_in || a > 8'h99) begin
                        r = r + 8'h60;
                        rsp.flag_c = 1'b1;
                    end
                    if (req.flag_h_in || r[3:0] > 4'h9) r = r + 8'h06;
                end else begin
                    if (req.flag_c_in) r = r - 8'h60;
                    if (req.flag_h_in) r = r - 8'h06;
                end
                rsp.result = {8'h00, r};
                rsp.flag_z = (r == 8'h00);
                rsp.flag_h = 1'b0;
            end
            OP_BIT: begin
                rsp.result = {8'h00, a};
                rsp.flag_z = ((a & bit_mask) == 8'h00);
                rsp.flag_n = 1'b0;
                rsp.flag_h = 1'b1;
            end
            OP_SET: rsp.result = {8'h00, a | bit_mask};
            OP_RES: rsp.result = {8'h00, a & ~bit_mask};
            OP_RL, OP_RR, OP_RLC, OP_RRC, OP_SLA, OP_SRA, OP_SRL, OP_SWAP: begin
                case (req.mode)
                    OP_RL:   r = {a[6:0], req.flag_c_in};
                    OP_RR:   r = {req.flag_c_in, a[7:1]};
                    OP_RLC:  r = {a[6:0], a[7]};
                    OP_RRC:  r = {a[0], a[7:1]};
                    OP_SLA:  r = {a[6:0], 1'b0};
                    OP_SRA:  r = {a[7], a[7:1]};
                    OP_SRL:  r = {1'b0, a[7:1]};
                    default: r = {a[3:0], a[7:4]};
                endcase
                case (req.mode)
                    OP_RL, OP_RLC, OP_SLA: cy = a[7];
                    OP_SWAP:               cy = 1'b0;
                    default:               cy = a[0];
                endcase
                rsp = '{flag_c: cy, flag_h: 1'b0, flag_n: 1'b0,
                        flag_z: (r == 8'h00), result: {8'h00, r}};
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // flags packed {c, h, n, z} to match the request layout
    function automatic t_alu_req make_op(input logic [OpWidth-1:0] op,
                                         input logic [15:0] a, input logic [15:0] b,
                                         input logic cy, input logic [2:0] bix,
                                         input logic [3:0] flags);
        t_alu_req req;
        req = '{flag_c_in: flags[3], flag_h_in: flags[2], flag_n_in: flags[1],
                flag_z_in: flags[0], bit_index: bix, carry_in: cy,
                operand_b: b, operand_a: a, mode: op};
        return req;
    endfunction

    task automatic send_op(input t_alu_req req);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= InDataWidth'(req);
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_rsp_q.push_back(alu_predict(req));
    endtask

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] got_val);
        if (exp_val !== got_val) begin
            $display("%0t mismatch on %s: expected %h, actual %h", $time, name, exp_val, got_val);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_alu_rsp got;
        t_alu_rsp exp_rsp;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_alu_rsp'(o_m_axis_tdata[$bits(t_alu_rsp)-1:0]);
            if (expected_rsp_q.size() == 0) begin
                $display("%0t unexpected result beat: expected none, actual %h", $time, got);
                mismatch_count++;
            end else begin
                exp_rsp = expected_rsp_q.pop_front();
                check_field("result", exp_rsp.result, got.result);
                check_field("flag_z", {15'd0, exp_rsp.flag_z}, {15'd0, got.flag_z});
                check_field("flag_n", {15'd0, exp_rsp.flag_n}, {15'd0, got.flag_n});
                check_field("flag_h", {15'd0, exp_rsp.flag_h}, {15'd0, got.flag_h});
                check_field("flag_c", {15'd0, exp_rsp.flag_c}, {15'd0, got.flag_c});
            end
        end
    end

    task automatic test_add_sub();
        send_op(make_op(OP_ADD, 16'hFFFF, 16'h0001, 1'b0, 3'd0, 4'b0000));
        send_op(make_op(OP_ADD, 16'h1208, 16'hAB07, 1'b1, 3'd7, 4'b1111));
        send_op(make_op(OP_SUB, 16'h0000, 16'hFFFF, 1'b1, 3'd0, 4'b0000));
        // compare ignores the carry-in and keeps the low byte of operand_a
        send_op(make_op(OP_CP, 16'hC33C, 16'h003C, 1'b1, 3'd0, 4'b0000));
    endtask

    task automatic test_logic_ops();
        send_op(make_op(OP_AND, 16'hFFFF, 16'h0000, 1'b0, 3'd0, 4'b1111));
        send_op(make_op(OP_XOR, 16'h00AA, 16'h0055, 1'b1, 3'd0, 4'b1111));
        send_op(make_op(OP_OR,  16'h0000, 16'h0000, 1'b0, 3'd0, 4'b0000));
    endtask

    task automatic test_inc_dec();
        send_op(make_op(OP_INC8,  16'h00FF, 16'h0000, 1'b0, 3'd0, 4'b0000));
        send_op(make_op(OP_DEC8,  16'h0010, 16'h0000, 1'b0, 3'd0, 4'b1000));
        send_op(make_op(OP_INC16, 16'hFFFF, 16'h0000, 1'b0, 3'd0, 4'b1010));
        send_op(make_op(OP_DEC16, 16'h0000, 16'hFFFF, 1'b1, 3'd0, 4'b0101));
    endtask

    task automatic test_wide_add();
        // z passes through and carry_in is ignored for the 16-bit add
        send_op(make_op(OP_ADD16, 16'h0FFF, 16'hF001, 1'b1, 3'd0, 4'b0001));
        send_op(make_op(OP_ADDSB, 16'h00FF, 16'h0080, 1'b1, 3'd0, 4'b0000));
        send_op(make_op(OP_ADDSB, 16'h1234, 16'hFFFF, 1'b0, 3'd0, 4'b1111));
    endtask

    task automatic test_daa();
        send_op(make_op(OP_DAA, 16'h009A, 16'h0000, 1'b0, 3'd0, 4'b0000));
        send_op(make_op(OP_DAA, 16'h00FF, 16'h0000, 1'b0, 3'd0, 4'b1110));
    endtask

    task automatic test_bit_ops();
        send_op(make_op(OP_BIT, 16'hFF7F, 16'h0000, 1'b0, 3'd7, 4'b0000));
        send_op(make_op(OP_SET, 16'h0000, 16'h0000, 1'b0, 3'd0, 4'b1111));
        send_op(make_op(OP_RES, 16'h00FF, 16'h0000, 1'b0, 3'd7, 4'b0000));
    endtask

    task automatic test_shifts();
        logic [15:0] a;
        for (int k = OP_RL; k <= OP_SWAP; k++) begin
            a = (k % 2 == 0) ? 16'hFF80 : 16'hFF01;
            send_op(make_op(OpWidth'(k), a, 16'h0000, 1'b0, 3'd0, {k % 3 == 0, 3'b111}));
        end
    endtask

    task automatic test_unused_modes();
        send_op(make_op(MODE_FIRST_UNUSED, 16'hBEEF, 16'h1234, 1'b1, 3'd5, 4'b1011));
        send_op(make_op(MODE_LAST_UNUSED,  16'h0000, 16'hFFFF, 1'b0, 3'd2, 4'b0100));
    endtask

    function automatic logic [15:0] pick_operand();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(9))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v[7:0] = 8'h0F;
            3: v[7:0] = 8'h80;
            4: v[7:0] = {4'($urandom_range(9)), 4'($urandom_range(9))};
            5: v[11:0] = 12'hFFF;
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_random(input int count);
        logic [OpWidth-1:0] op;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(15) == 0) op = MODE_FIRST_UNUSED + OpWidth'($urandom_range(7));
            else                         op = OpWidth'($urandom_range(OP_SWAP));
            send_op(make_op(op, pick_operand(), pick_operand(), 1'($urandom),
                            3'($urandom), 4'($urandom)));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 79;
        test_add_sub();
        test_logic_ops();
        test_inc_dec();
        test_wide_add();
        test_daa();
        test_bit_ops();
        test_shifts();
        test_unused_modes();
        test_random(200);

        send_idle_pct = 79;
        recv_idle_pct = 34;
        test_random(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(200);

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        // two-stage pipe, give any stray beat a chance to show up
        repeat (6) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("sm83_alu_with_flags_tb: clean");
        end else begin
            $display("sm83_alu_with_flags_tb: errors");
        end
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("sm83_alu_with_flags_tb: errors");
        $finish;
    end

endmodule

### files.f
src/sm83alu_pkg.sv
src/sm83alu_core.sv
src/sm83_alu_with_flags.sv
verif/sm83_alu_with_flags_tb.sv
